### hw/rtl/vps_pkg.sv
// ----------------------------------------------------------------------------
// vps_pkg: shared constants and helpers for the vertex projection block
// Register map, item kinds, default fixed-point format and saturation.
// ----------------------------------------------------------------------------
package vps_pkg;

	localparam int FRACTION_BITS_DEF = 16;

	// item kind carried on tuser
	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_PROJECT = 1'b1;

	// register index (paddr[3:2])
	localparam logic [1:0] REG_ORIGIN_X = 2'd0;
	localparam logic [1:0] REG_ORIGIN_Y = 2'd1;
	localparam logic [1:0] REG_SIZE_X   = 2'd2;
	localparam logic [1:0] REG_SIZE_Y   = 2'd3;

	localparam logic [12:0] SIZE_X_RST = 13'd1920;
	localparam logic [12:0] SIZE_Y_RST = 13'd1080;

	// clamp to the signed 32-bit range
	function automatic logic [31:0] sat32(input logic signed [63:0] x);
		logic [31:0] r;
		if (x > 64'sd2147483647) begin
			r = 32'h7fff_ffff;
		end else if (x < -64'sd2147483648) begin
			r = 32'h8000_0000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

endpackage

### hw/rtl/vertex_project_to_screen.sv
// ----------------------------------------------------------------------------
// vertex_project_to_screen: 4x4 transform, perspective divide, viewport map
// Fixed-point vertex projection with a fully pipelined divider.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): tuser = 0 loads one matrix coefficient, tuser = 1
//   projects a point. Loads give no output beat; each point gives one beat
//   on the output stream (m_*) holding screen x, y and depth.
//   The APB port sets viewport origin and size; write it only while idle.
// Throughput: one beat per clock while the output is not held, loads and
//   points mixed freely. A load takes effect for the next beat; points
//   already in flight keep the coefficients they captured.
// Pipeline: s1 products, s2 row sums, s3 w fixup, then the divider with
//   one quotient bit per stage, 32 + FRACTION_BITS stages, x, y and z in
//   parallel lanes, then s5 quotients, s6 viewport scale, output register.
// Reset: matrix goes to identity, origin to 0, size to 1920 x 1080, the
//   pipeline empties.
// Stall: when the output beat is held the whole pipeline freezes and
//   s_tready drops; nothing is lost or repeated, and empty stages let
//   new beats in as soon as the output moves.
module vertex_project_to_screen #(
	parameter int FRACTION_BITS = vps_pkg::FRACTION_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	// slave stream
	input  logic         s_tvalid,
	output logic         s_tready,
	// [3:0] coeff_slot, [35:4] coeff_value, [67:36] world_x,
	// [99:68] world_y, [131:100] world_z, [135:132] zero
	input  logic [135:0] s_tdata,
	// [0] op
	input  logic         s_tuser,
	// master stream
	output logic         m_tvalid,
	input  logic         m_tready,
	// [31:0] screen_x, [63:32] screen_y, [95:64] screen_depth
	output logic [95:0]  m_tdata,
	// APB configuration
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int F  = FRACTION_BITS;
	localparam int DW = 32 + F;                    // dividend / quotient bits
	localparam int AW = 32 + DW;                   // remainder + dividend
	localparam int WMIN = ((1 << F) - 1) / 10000;  // largest |w| taken as zero
	localparam logic signed [32:0] ONE = 33'sd1 <<< F;

	// ---------------- configuration ----------------
	logic [11:0] origin_x_q, origin_y_q;
	logic [12:0] size_x_q, size_y_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			size_x_q   <= vps_pkg::SIZE_X_RST;
			size_y_q   <= vps_pkg::SIZE_Y_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				vps_pkg::REG_ORIGIN_X: origin_x_q <= pwdata[11:0];
				vps_pkg::REG_ORIGIN_Y: origin_y_q <= pwdata[11:0];
				vps_pkg::REG_SIZE_X:   size_x_q   <= pwdata[12:0];
				vps_pkg::REG_SIZE_Y:   size_y_q   <= pwdata[12:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			vps_pkg::REG_ORIGIN_X: prdata = {20'd0, origin_x_q};
			vps_pkg::REG_ORIGIN_Y: prdata = {20'd0, origin_y_q};
			vps_pkg::REG_SIZE_X:   prdata = {19'd0, size_x_q};
			vps_pkg::REG_SIZE_Y:   prdata = {19'd0, size_y_q};
			default:               prdata = '0;
		endcase
	end

	// ---------------- input and matrix ----------------
	logic        adv;   // whole pipeline moves
	logic [3:0]  in_slot;
	logic [31:0] in_coeff;
	logic [31:0] in_pt [3];
	logic        in_load, in_proj;
	logic [31:0] mat_q [16];

	assign adv      = ~m_tvalid | m_tready;
	assign s_tready = adv;
	assign in_slot  = s_tdata[3:0];
	assign in_coeff = s_tdata[35:4];
	assign in_pt[0] = s_tdata[67:36];
	assign in_pt[1] = s_tdata[99:68];
	assign in_pt[2] = s_tdata[131:100];
	assign in_load  = s_tvalid & adv & (s_tuser == vps_pkg::OP_LOAD);
	assign in_proj  = s_tvalid & (s_tuser == vps_pkg::OP_PROJECT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				mat_q[i] <= (i % 5 == 0) ? 32'(ONE) : 32'd0;
			end
		end else if (in_load) begin
			mat_q[in_slot] <= in_coeff;
		end
	end

	// ---------------- s1: twelve products ----------------
	logic                v_s1;
	logic signed [63:0]  prod_s1 [4][3];
	logic signed [31:0]  off_s1  [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_proj;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 4; r++) begin
				for (int c = 0; c < 3; c++) begin
					prod_s1[r][c] <= $signed(mat_q[r*4+c]) * $signed(in_pt[c]);
				end
				off_s1[r] <= $signed(mat_q[r*4+3]);
			end
		end
	end

	// ---------------- s2: row sums ----------------
	logic               v_s2;
	logic [31:0]        row_s2 [4];
	logic signed [63:0] rsum [4];

	always_comb begin
		for (int r = 0; r < 4; r++) begin
			rsum[r] = (prod_s1[r][0] >>> F) + (prod_s1[r][1] >>> F)
			        + (prod_s1[r][2] >>> F) + 64'(off_s1[r]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 4; r++) begin
				row_s2[r] <= vps_pkg::sat32(rsum[r]);
			end
		end
	end

	// ---------------- s3: w fixup, signs, magnitudes ----------------
	logic [31:0] w_mag, n_mag [3];
	logic        w_neg, w_small;

	always_comb begin
		w_neg   = row_s2[3][31];
		w_mag   = w_neg ? (~row_s2[3] + 32'd1) : row_s2[3];
		w_small = w_mag <= 32'(WMIN);
		for (int r = 0; r < 3; r++) begin
			n_mag[r] = row_s2[r][31] ? (~row_s2[r] + 32'd1) : row_s2[r];
		end
	end

	// divider pipe: index 0 is stage 3, index DW is the last bit stage
	logic          div_v   [DW+1];
	logic [31:0]   div_d   [DW+1];
	logic [2:0]    div_neg [DW+1];
	logic [AW-1:0] div_acc [DW+1][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_v[0] <= 1'b0;
		end else if (adv) begin
			div_v[0] <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			div_d[0] <= w_small ? 32'(ONE) : w_mag;
			for (int r = 0; r < 3; r++) begin
				div_neg[0][r] <= row_s2[r][31] ^ (w_neg & ~w_small);
				div_acc[0][r] <= {32'd0, n_mag[r], F'(0)};
			end
		end
	end

	// one restoring quotient bit per stage
	for (genvar k = 0; k < DW; k++) begin : g_div
		logic [32:0]   trial [3];
		logic [32:0]   diff  [3];
		logic [AW-1:0] nxt   [3];

		always_comb begin
			for (int r = 0; r < 3; r++) begin
				trial[r] = {div_acc[k][r][AW-1:DW], div_acc[k][r][DW-1]};
				diff[r]  = trial[r] - {1'b0, div_d[k]};
				if (!diff[r][32]) begin
					nxt[r] = {diff[r][31:0], div_acc[k][r][DW-2:0], 1'b1};
				end else begin
					nxt[r] = {trial[r][31:0], div_acc[k][r][DW-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_v[k+1] <= 1'b0;
			end else if (adv) begin
				div_v[k+1] <= div_v[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				div_d[k+1]   <= div_d[k];
				div_neg[k+1] <= div_neg[k];
				for (int r = 0; r < 3; r++) begin
					div_acc[k+1][r] <= nxt[r];
				end
			end
		end
	end

	// ---------------- s5: signed, saturated quotients ----------------
	logic               v_s5;
	logic [31:0]        clip_s5 [3];
	logic signed [63:0] quo [3];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			quo[r] = $signed(64'(div_acc[DW][r][DW-1:0]));
			if (div_neg[DW][r]) begin
				quo[r] = -quo[r];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= div_v[DW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 3; r++) begin
				clip_s5[r] <= vps_pkg::sat32(quo[r]);
			end
		end
	end

	// ---------------- s6: viewport scale ----------------
	logic               v_s6;
	logic signed [46:0] sx_s6, sy_s6;
	logic [31:0]        cz_s6;
	logic signed [32:0] ax, ay;

	assign ax = $signed({clip_s5[0][31], clip_s5[0]}) + ONE;
	assign ay = ONE - $signed({clip_s5[1][31], clip_s5[1]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sx_s6 <= ax * $signed({1'b0, size_x_q});
			sy_s6 <= ay * $signed({1'b0, size_y_q});
			cz_s6 <= clip_s5[2];
		end
	end

	// ---------------- output register ----------------
	logic signed [46:0] hx, hy;
	logic signed [63:0] fx, fy;
	logic [31:0]        out_x_q, out_y_q, out_z_q;
	logic               out_v_q;

	// halve, truncating toward zero, then add the origin
	assign hx = (sx_s6 + $signed(47'(sx_s6[46]))) >>> 1;
	assign hy = (sy_s6 + $signed(47'(sy_s6[46]))) >>> 1;
	assign fx = 64'(hx) + $signed(64'(origin_x_q) << F);
	assign fy = 64'(hy) + $signed(64'(origin_y_q) << F);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_x_q <= vps_pkg::sat32(fx);
			out_y_q <= vps_pkg::sat32(fy);
			out_z_q <= cz_s6;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {out_z_q, out_y_q, out_x_q};

endmodule
